// File: src/pwfd_pkg.sv
// ----------------------------------------------------------------------------
// pwfd_pkg
// Shared widths, register indexes and reset values for the pulse-width
// frame decoder.
// ----------------------------------------------------------------------------
package pwfd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DataW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SelW    = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam int unsigned FrameBitsDef = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MIN = 3'd0,
    CFG_START_MAX = 3'd1,
    CFG_ZERO_MAX  = 3'd2,
    CFG_ONE_MIN   = 3'd3,
    CFG_ONE_MAX   = 3'd4,
    CFG_SCALE_TOP = 3'd5,
    CFG_NEAR_LIM  = 3'd6,
    CFG_NO_RANGE  = 3'd7
  } cfg_idx_e;

  localparam logic [CfgW-1:0]  StartMinRst  = 16'd500;
  localparam logic [CfgW-1:0]  StartMaxRst  = 16'd1500;
  localparam logic [CfgW-1:0]  ZeroMaxRst   = 16'd180;
  localparam logic [CfgW-1:0]  OneMinRst    = 16'd250;
  localparam logic [CfgW-1:0]  OneMaxRst    = 16'd350;
  localparam logic [ByteW-1:0] ScaleTopRst  = 8'd20;
  localparam logic [ByteW-1:0] NearLimRst   = 8'd2;
  localparam logic [ByteW-1:0] NoRangeRst   = 8'd255;

  typedef struct packed {
    logic              ready_res;
    logic [DataW-1:0]  frame_data;
    logic [ByteW-1:0]  distance;
    logic              frame_done;
    logic              frame_error;
  } result_t;

endpackage

// File: src/pwfd_if.sv
// ----------------------------------------------------------------------------
// pwfd_if
// Valid/ready channels for edge/read words in and decoded result words out.
// ----------------------------------------------------------------------------
interface pwfd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic                         line_level;
  logic [pwfd_pkg::TimeW-1:0]   time_us;
  logic [pwfd_pkg::SelW-1:0]    sensor_select;

  modport source (output valid, command, line_level, time_us, sensor_select,
                  input ready);
  modport sink   (input valid, command, line_level, time_us, sensor_select,
                  output ready);
endinterface

interface pwfd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ready_res;
  logic [pwfd_pkg::DataW-1:0]   frame_data;
  logic [pwfd_pkg::ByteW-1:0]   distance;
  logic                         frame_done;
  logic                         frame_error;

  modport source (output valid, ready_res, frame_data, distance, frame_done,
                  frame_error, input ready);
  modport sink   (input valid, ready_res, frame_data, distance, frame_done,
                  frame_error, output ready);
endinterface

// File: src/pulse_width_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_decoder_top
// Pulse-width frame decoder: edge timestamps in, frame bits and distance out.
// ----------------------------------------------------------------------------
// One result word per input word. A word is captured in the input register,
// decoded against the decoder state and written to the result register, and
// a new word can enter every cycle while results are taken. A falling edge
// measures the high time from the stored rising edge as a signed 32-bit
// difference; a start-window pulse arms reception, data pulses shift bits in,
// and after FrameBits bits the ready flag is set. A read word returns the flag
// and clears it. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i,
// by the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pulse_width_frame_decoder_top #(
  parameter int unsigned FrameBits = pwfd_pkg::FrameBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwfd_pkg::CfgW-1:0]     cfg_data_i,
  pwfd_in_if.sink                       in_i,
  pwfd_out_if.source                    out_o
);

  localparam int unsigned CntW = $clog2(FrameBits + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(FrameBits - 1);

  // configuration
  logic [pwfd_pkg::CfgW-1:0]  start_min_q, start_max_q, zero_max_q;
  logic [pwfd_pkg::CfgW-1:0]  one_min_q, one_max_q;
  logic [pwfd_pkg::ByteW-1:0] scale_top_q, near_lim_q, no_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min_q <= pwfd_pkg::StartMinRst;
      start_max_q <= pwfd_pkg::StartMaxRst;
      zero_max_q  <= pwfd_pkg::ZeroMaxRst;
      one_min_q   <= pwfd_pkg::OneMinRst;
      one_max_q   <= pwfd_pkg::OneMaxRst;
      scale_top_q <= pwfd_pkg::ScaleTopRst;
      near_lim_q  <= pwfd_pkg::NearLimRst;
      no_range_q  <= pwfd_pkg::NoRangeRst;
    end else if (cfg_we_i) begin
      case (pwfd_pkg::cfg_idx_e'(cfg_idx_i))
        pwfd_pkg::CFG_START_MIN: start_min_q <= cfg_data_i;
        pwfd_pkg::CFG_START_MAX: start_max_q <= cfg_data_i;
        pwfd_pkg::CFG_ZERO_MAX:  zero_max_q  <= cfg_data_i;
        pwfd_pkg::CFG_ONE_MIN:   one_min_q   <= cfg_data_i;
        pwfd_pkg::CFG_ONE_MAX:   one_max_q   <= cfg_data_i;
        pwfd_pkg::CFG_SCALE_TOP: scale_top_q <= cfg_data_i[pwfd_pkg::ByteW-1:0];
        pwfd_pkg::CFG_NEAR_LIM:  near_lim_q  <= cfg_data_i[pwfd_pkg::ByteW-1:0];
        pwfd_pkg::CFG_NO_RANGE:  no_range_q  <= cfg_data_i[pwfd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                         in_v_q;
  logic                         cmd_q, lvl_q;
  logic [pwfd_pkg::TimeW-1:0]   time_q;
  logic [pwfd_pkg::SelW-1:0]    sel_q;
  logic                         advance;
  logic                         out_v_q;
  pwfd_pkg::result_t            res_q, res_d;

  assign advance  = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      lvl_q  <= in_i.line_level;
      time_q <= in_i.time_us;
      sel_q  <= in_i.sensor_select;
    end
  end

  // decoder state
  logic [pwfd_pkg::TimeW-1:0] rise_q, rise_d;
  logic                       recv_q, recv_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [pwfd_pkg::DataW-1:0] shift_q, shift_d;
  logic                       rdy_q, rdy_d;

  logic signed [pwfd_pkg::TimeW-1:0] width;
  logic                              is_start, is_zero, is_one;
  logic [pwfd_pkg::ByteW-1:0]        byte_sel, inv;

  assign width    = $signed(time_q - rise_q);
  assign is_start = (width > $signed({16'd0, start_min_q}))
                 && (width < $signed({16'd0, start_max_q}));
  assign is_zero  = width < $signed({16'd0, zero_max_q});
  assign is_one   = (width > $signed({16'd0, one_min_q}))
                 && (width < $signed({16'd0, one_max_q}));

  always_comb begin
    rise_d  = rise_q;
    recv_d  = recv_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rdy_d   = rdy_q;
    res_d   = '0;
    if (cmd_q) begin
      res_d.ready_res = rdy_q;
      rdy_d = 1'b0;
    end else begin
      if (lvl_q) begin
        rise_d = time_q;
      end else if (!recv_q) begin
        recv_d = is_start;
      end else if (is_zero || is_one) begin
        shift_d = {shift_q[pwfd_pkg::DataW-2:0], !is_zero};
        if (cnt_q == CntLast) begin
          recv_d = 1'b0;
          cnt_d  = '0;
          rdy_d  = 1'b1;
          res_d.frame_done = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        recv_d = 1'b0;
        cnt_d  = '0;
        res_d.frame_error = 1'b1;
      end
      res_d.ready_res = rdy_d;
    end
    res_d.frame_data = shift_d;
    byte_sel = (sel_q == 3'd1 || sel_q == 3'd2) ? shift_d[15:8] : shift_d[7:0];
    inv = scale_top_q - (byte_sel - 8'd1);
    if (byte_sel == '0) begin
      res_d.distance = no_range_q;
    end else if (inv <= near_lim_q) begin
      res_d.distance = '0;
    end else begin
      res_d.distance = inv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= '0;
      recv_q  <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
      rdy_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (advance) begin
        rise_q  <= rise_d;
        recv_q  <= recv_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        rdy_q   <= rdy_d;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.ready_res   = res_q.ready_res;
  assign out_o.frame_data  = res_q.frame_data;
  assign out_o.distance    = res_q.distance;
  assign out_o.frame_done  = res_q.frame_done;
  assign out_o.frame_error = res_q.frame_error;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast) else $error("bit count past frame length");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recv_q |-> cnt_q == '0) else $error("bit count nonzero while idle");

  a_done_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.frame_done |=> rdy_q && res_q.ready_res)
    else $error("completed frame without ready");

  a_done_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(res_q.frame_done && res_q.frame_error))
    else $error("done and error in one word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(shift_q) && $stable(rdy_q) && $stable(recv_q))
    else $error("decoder state moved without a word");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width frame decoder. Drives edge and
// read words with random idling on both channels and walks through several
// threshold settings. A scoreboard class decodes each accepted word on its
// own copy of the line state and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DirectedWords = 21;
  localparam int unsigned PhaseWords    = 190;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned TotalWords    = DirectedWords + NumPhases * PhaseWords;
  localparam int unsigned CycleLimit    = 200000;

  typedef enum int {PW_START, PW_ZERO, PW_ONE, PW_BAD} pulse_kind_e;

  class frame_scoreboard;
    pwfd_pkg::result_t decoded_q[$];
    int unsigned mismatches;
    bit [15:0]   start_min, start_max, zero_max, one_min, one_max;
    bit [7:0]    scale_top, near_limit, no_range;
    bit [31:0]   rise_time;
    bit          receiving;
    bit [4:0]    bit_count;
    bit [15:0]   shift_data;
    bit          ready_flag;

    function new();
      start_min  = pwfd_pkg::StartMinRst;
      start_max  = pwfd_pkg::StartMaxRst;
      zero_max   = pwfd_pkg::ZeroMaxRst;
      one_min    = pwfd_pkg::OneMinRst;
      one_max    = pwfd_pkg::OneMaxRst;
      scale_top  = pwfd_pkg::ScaleTopRst;
      near_limit = pwfd_pkg::NearLimRst;
      no_range   = pwfd_pkg::NoRangeRst;
      rise_time  = '0;
      receiving  = 1'b0;
      bit_count  = '0;
      shift_data = '0;
      ready_flag = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(pwfd_pkg::cfg_idx_e idx, bit [15:0] val);
      case (idx)
        pwfd_pkg::CFG_START_MIN: start_min  = val;
        pwfd_pkg::CFG_START_MAX: start_max  = val;
        pwfd_pkg::CFG_ZERO_MAX:  zero_max   = val;
        pwfd_pkg::CFG_ONE_MIN:   one_min    = val;
        pwfd_pkg::CFG_ONE_MAX:   one_max    = val;
        pwfd_pkg::CFG_SCALE_TOP: scale_top  = val[7:0];
        pwfd_pkg::CFG_NEAR_LIM:  near_limit = val[7:0];
        pwfd_pkg::CFG_NO_RANGE:  no_range   = val[7:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] range_of(bit [2:0] sel);
      bit [7:0] raw;
      bit [7:0] inv;
      raw = (sel == 3'd1 || sel == 3'd2) ? shift_data[15:8] : shift_data[7:0];
      if (raw == 8'd0) return no_range;
      inv = scale_top - (raw - 8'd1);
      return (inv <= near_limit) ? 8'd0 : inv;
    endfunction

    function void note_word(bit cmd, bit lvl, bit [31:0] t, bit [2:0] sel);
      pwfd_pkg::result_t exp;
      bit [31:0] diff;
      int        w;
      exp = '0;
      if (cmd) begin
        exp.ready_res = ready_flag;
        ready_flag = 1'b0;
      end else begin
        if (lvl) begin
          rise_time = t;
        end else begin
          diff = t - rise_time;
          w = $signed(diff);
          if (!receiving && w > int'(start_min) && w < int'(start_max)) begin
            receiving = 1'b1;
          end else if (receiving) begin
            if (w < int'(zero_max) || (w > int'(one_min) && w < int'(one_max))) begin
              shift_data = {shift_data[14:0], !(w < int'(zero_max))};
              bit_count++;
              if (bit_count == pwfd_pkg::FrameBitsDef) begin
                receiving = 1'b0;
                ready_flag = 1'b1;
                bit_count = '0;
                exp.frame_done = 1'b1;
              end
            end else begin
              receiving = 1'b0;
              bit_count = '0;
              exp.frame_error = 1'b1;
            end
          end
        end
        exp.ready_res = ready_flag;
      end
      exp.frame_data = shift_data;
      exp.distance   = range_of(sel);
      decoded_q.push_back(exp);
    endfunction

    function void compare(string name, logic [15:0] e, logic [15:0] g);
      if (g !== e) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, g);
        mismatches++;
      end
    endfunction

    function void check_word(pwfd_pkg::result_t got);
      pwfd_pkg::result_t exp;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual data %0h", $time,
                 got.frame_data);
        mismatches++;
        return;
      end
      exp = decoded_q.pop_front();
      compare("ready_res", exp.ready_res, got.ready_res);
      compare("frame_data", exp.frame_data, got.frame_data);
      compare("distance", exp.distance, got.distance);
      compare("frame_done", exp.frame_done, got.frame_done);
      compare("frame_error", exp.frame_error, got.frame_error);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pwfd_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pwfd_pkg::CfgW-1:0]     cfg_data_i;

  pwfd_in_if  word_in ();
  pwfd_out_if word_out ();

  pulse_width_frame_decoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (word_in),
    .out_o      (word_out)
  );

  frame_scoreboard sb = new();
  bit              idle_on;
  bit [31:0]       clock_us;
  int unsigned     words_sent;
  int unsigned     cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && word_out.valid && word_out.ready) begin
      sb.check_word(pwfd_pkg::result_t'{ready_res:   word_out.ready_res,
                                        frame_data:  word_out.frame_data,
                                        distance:    word_out.distance,
                                        frame_done:  word_out.frame_done,
                                        frame_error: word_out.frame_error});
    end
  end

  initial begin
    word_out.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        word_out.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        word_out.ready <= 1'b1;
      end
    end
  end

  task automatic drive_word(bit cmd, bit lvl, bit [31:0] t, bit [2:0] sel);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      word_in.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    word_in.valid         <= 1'b1;
    word_in.command       <= cmd;
    word_in.line_level    <= lvl;
    word_in.time_us       <= t;
    word_in.sensor_select <= sel;
    do @(posedge clk_i); while (!word_in.ready);
    sb.note_word(cmd, lvl, t, sel);
    words_sent++;
  endtask

  task automatic read_frame();
    drive_word(1'b1, 1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic drive_pulse(bit [31:0] w);
    bit [31:0] rise_t;
    rise_t = clock_us;
    drive_word(1'b0, 1'b1, rise_t, 3'($urandom_range(0, 7)));
    drive_word(1'b0, 1'b0, rise_t + w, 3'($urandom_range(0, 7)));
    clock_us = rise_t + (w[31] ? 32'd0 : w) + $urandom_range(1, 400);
  endtask

  function automatic bit [31:0] pulse_width(pulse_kind_e k);
    case (k)
      PW_START: begin
        if (sb.start_max > sb.start_min + 1)
          return $urandom_range(sb.start_min + 1, sb.start_max - 1);
        return $urandom_range(0, 2000);
      end
      PW_ZERO: begin
        if (sb.zero_max == 0 || $urandom_range(0, 7) == 0)
          return -$urandom_range(1, 100000);
        return $urandom_range(0, sb.zero_max - 1);
      end
      PW_ONE: begin
        if (sb.one_max > sb.one_min + 1)
          return $urandom_range(sb.one_min + 1, sb.one_max - 1);
        return $urandom_range(0, 2000);
      end
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'(sb.zero_max);
          1: return 32'(sb.one_min);
          2: return 32'(sb.one_max);
          3: return 32'(sb.start_min);
          4: return 32'(sb.start_max);
          5: return $urandom;
          default: return $urandom_range(0, 70000);
        endcase
      end
    endcase
  endfunction

  task automatic run_frame();
    int r;
    pulse_kind_e k;
    if ($urandom_range(0, 9) == 0) drive_pulse(pulse_width(PW_BAD));
    else drive_pulse(pulse_width(PW_START));
    repeat (pwfd_pkg::FrameBitsDef) begin
      r = $urandom_range(0, 99);
      if (r < 46) k = PW_ZERO;
      else if (r < 92) k = PW_ONE;
      else if (r < 96) k = PW_BAD;
      else k = PW_START;
      drive_pulse(pulse_width(k));
    end
    if ($urandom_range(0, 4) != 0) read_frame();
  endtask

  task automatic drive_noise();
    case ($urandom_range(0, 2))
      0: drive_word(1'b0, 1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
      1: drive_pulse(pulse_width(PW_BAD));
      default: read_frame();
    endcase
  endtask

  task automatic run_random(int unsigned upto);
    while (words_sent < upto) begin
      if (words_sent + 150 > TotalWords) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) clock_us = $urandom;
        else clock_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end
      if ($urandom_range(0, 3) != 0) run_frame();
      else drive_noise();
    end
  endtask

  task automatic settle();
    word_in.valid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(pwfd_pkg::cfg_idx_e idx, bit [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic load_settings(int p);
    bit [15:0] v[8];
    settle();
    case (p)
      2: foreach (v[i]) v[i] = '0;
      3: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF, 16'hFF, 16'hFF};
      4: v = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0,
               16'($urandom_range(0, 255))};
      7: v = '{pwfd_pkg::StartMinRst, pwfd_pkg::StartMaxRst, pwfd_pkg::ZeroMaxRst,
               pwfd_pkg::OneMinRst, pwfd_pkg::OneMaxRst, 16'(pwfd_pkg::ScaleTopRst),
               16'(pwfd_pkg::NearLimRst), 16'(pwfd_pkg::NoRangeRst)};
      default: begin
        v[0] = 16'($urandom_range(200, 900));
        v[1] = 16'(v[0] + $urandom_range(2, 1500));
        v[2] = 16'($urandom_range(1, 300));
        v[3] = 16'(v[2] + $urandom_range(0, 100));
        v[4] = 16'(v[3] + $urandom_range(2, 300));
        v[5] = 16'($urandom_range(0, 255));
        v[6] = 16'($urandom_range(0, 255));
        v[7] = 16'($urandom_range(0, 255));
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(pwfd_pkg::cfg_idx_e'(i), v[i]);
    cfg_we_i <= 1'b0;
  endtask

  // default thresholds: start 500..1500, zero below 180, one 250..350
  task automatic run_directed();
    read_frame();
    drive_word(1'b0, 1'b0, 32'd0, 3'd3);
    drive_word(1'b0, 1'b1, 32'hFFFF_FF00, 3'd1);
    drive_word(1'b0, 1'b0, 32'h0000_02BC, 3'd2);   // wraps, arms
    drive_word(1'b0, 1'b1, 32'd1000, 3'd0);
    drive_word(1'b0, 1'b0, 32'd1100, 3'd4);
    drive_word(1'b0, 1'b1, 32'd2000, 3'd5);
    drive_word(1'b0, 1'b0, 32'd2300, 3'd6);
    drive_word(1'b0, 1'b1, 32'd3000, 3'd7);
    drive_word(1'b0, 1'b0, 32'd2500, 3'd1);         // negative high time
    drive_word(1'b0, 1'b1, 32'hFFFF_FFFF, 3'd2);
    drive_word(1'b0, 1'b0, 32'd0, 3'd0);
    drive_word(1'b0, 1'b1, 32'd4000, 3'd3);
    drive_word(1'b0, 1'b0, 32'd5000, 3'd1);         // start width mid-frame
    drive_word(1'b0, 1'b1, 32'd6000, 3'd2);
    drive_word(1'b0, 1'b0, 32'd5000, 3'd4);
    drive_word(1'b0, 1'b1, 32'd7000, 3'd5);
    drive_word(1'b0, 1'b0, 32'd7180, 3'd6);
    drive_word(1'b1, 1'b1, 32'hFFFF_FFFF, 3'd1);
    drive_word(1'b1, 1'b0, 32'd0, 3'd7);
    drive_word(1'b1, 1'b1, 32'h5555_AAAA, 3'd2);
  endtask

  initial begin
    idle_on    = 1'b1;
    clock_us   = $urandom;
    words_sent = 0;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= pwfd_pkg::CFG_START_MIN;
    cfg_data_i            <= '0;
    word_in.valid         <= 1'b0;
    word_in.command       <= 1'b0;
    word_in.line_level    <= 1'b0;
    word_in.time_us       <= '0;
    word_in.sensor_select <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) load_settings(p);
      run_random(DirectedWords + (p + 1) * PhaseWords);
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
